// File: hdl/thr_pkg.sv
// ----------------------------------------------------------------------------
// thr_pkg: shared types and constants of the timestamped history ring
// Holds field widths, opcode and status codes, the command item passed from
// the front end to the back end, and the back end state encoding.
// ----------------------------------------------------------------------------
package thr_pkg;

    // Field widths of the item and result channels.
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RETENTION_RESET = 32'd2592000;
    localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET  = 32'd21600;

    // Default store depth and the time that a valid clock must exceed.
    localparam int CAPACITY_DEFAULT = 1024;
    localparam logic [TIME_W-1:0] CLOCK_VALID_MIN = 32'd1000000000;

    // Depth of the command queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_RESTORE = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 3'd0,
        ST_CLOCK = 3'd1,
        ST_SOON  = 3'd2,
        ST_RANGE = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    // Command kinds after classification in the front end.
    typedef enum logic [2:0] {
        K_ADD,
        K_BAD_CLOCK,
        K_READ,
        K_CLEAR,
        K_RESTORE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [TIME_W-1:0]  now;
        logic [VAL_W-1:0]   value;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PRUNE_RD,
        S_PRUNE_CHK,
        S_LAST_RD,
        S_LAST_CHK,
        S_APPEND,
        S_READ_WAIT,
        S_RESULT
    } t_back_state;

endpackage

// File: hdl/thr_in_if.sv
// ----------------------------------------------------------------------------
// thr_in_if: item channel of the timestamped history ring
// Carries one operation request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface thr_in_if;
    import thr_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [TIME_W-1:0]   now_seconds;
    logic [VAL_W-1:0]    sample_value;
    logic [IDX_W-1:0]    entry_index;

    modport source (
        output valid, opcode, now_seconds, sample_value, entry_index,
        input  ready
    );

    modport sink (
        input  valid, opcode, now_seconds, sample_value, entry_index,
        output ready
    );
endinterface

// File: hdl/thr_out_if.sv
// ----------------------------------------------------------------------------
// thr_out_if: result channel of the timestamped history ring
// Carries one operation result with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface thr_out_if;
    import thr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   stored_count;
    logic [TIME_W-1:0]    read_time;
    logic [VAL_W-1:0]     read_value;

    modport source (
        output valid, status, stored_count, read_time, read_value,
        input  ready
    );

    modport sink (
        input  valid, status, stored_count, read_time, read_value,
        output ready
    );
endinterface

// File: hdl/thr_front.sv
// ----------------------------------------------------------------------------
// thr_front: item intake and classification
// Accepts items, checks the clock of add requests and registers one
// classified command for the queue.
// ----------------------------------------------------------------------------
module thr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    thr_in_if.sink        i_item,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output thr_pkg::t_cmd o_cmd
);
    import thr_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // The stage takes a new item when it is empty or drains this cycle.
    assign i_item.ready = !r_valid || i_cmd_ready;
    assign accept       = i_item.valid && i_item.ready;

    // Classify the request; an add with an invalid clock becomes its own kind.
    always_comb begin
        n_cmd.now   = i_item.now_seconds;
        n_cmd.value = i_item.sample_value;
        n_cmd.idx   = i_item.entry_index;
        case (t_opcode'(i_item.opcode))
            OP_ADD: begin
                n_cmd.kind = (i_item.now_seconds > CLOCK_VALID_MIN) ? K_ADD : K_BAD_CLOCK;
            end
            OP_READ:    n_cmd.kind = K_READ;
            OP_CLEAR:   n_cmd.kind = K_CLEAR;
            OP_RESTORE: n_cmd.kind = K_RESTORE;
            default:    n_cmd.kind = K_CLEAR;
        endcase
    end

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Command payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

// File: hdl/thr_queue.sv
// ----------------------------------------------------------------------------
// thr_queue: short command queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module thr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  thr_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output thr_pkg::t_cmd o_pop_cmd
);
    import thr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_slots[r_rd_ptr];

    // Pointers and fill level, wrapping at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_cmd;
        end
    end
endmodule

// File: hdl/thr_back.sv
// ----------------------------------------------------------------------------
// thr_back: record store and operation sequencer
// Holds the record memory, ring pointers and configuration registers, walks
// expired records one at a time and registers each result item.
// ----------------------------------------------------------------------------
module thr_back #(
    parameter int CAPACITY = thr_pkg::CAPACITY_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [thr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [thr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  thr_pkg::t_cmd                   i_cmd,
    thr_out_if.source                       o_result
);
    import thr_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam int MW = TIME_W + VAL_W;

    // Ring position of the record at an offset from a base position.
    function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(CAPACITY)) begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[PW-1:0];
    endfunction

    logic [MW-1:0]     mem [CAPACITY];
    logic [MW-1:0]     r_rd_data;
    logic [PW-1:0]     rd_addr;
    logic              mem_we;
    logic [PW-1:0]     wr_addr;

    t_back_state       r_state, n_state;
    t_cmd              r_cmd;
    logic [PW-1:0]     r_oldest, n_oldest;
    logic [CW-1:0]     r_count, n_count;
    logic [TIME_W-1:0] r_retention;
    logic [TIME_W-1:0] r_interval;

    t_status           r_res_status, n_res_status;
    logic [TIME_W-1:0] r_res_time, n_res_time;
    logic [VAL_W-1:0]  r_res_value, n_res_value;

    logic              r_out_valid;
    logic              out_load;
    t_status           r_out_status;
    logic [CW-1:0]     r_out_count;
    logic [TIME_W-1:0] r_out_time;
    logic [VAL_W-1:0]  r_out_value;

    logic [TIME_W-1:0] rd_time;
    logic [TIME_W-1:0] age;

    assign rd_time     = r_rd_data[MW-1:VAL_W];
    assign age         = r_cmd.now - rd_time;
    assign o_cmd_ready = (r_state == S_IDLE);

    // Sequencer: next state, memory access and result fields.
    always_comb begin
        n_state      = r_state;
        n_oldest     = r_oldest;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_time   = r_res_time;
        n_res_value  = r_res_value;
        rd_addr      = r_oldest;
        mem_we       = 1'b0;
        wr_addr      = slot(r_oldest, r_count);
        out_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_status = ST_DONE;
                n_res_time   = '0;
                n_res_value  = '0;
                rd_addr      = slot(r_oldest, CW'(r_cmd.idx));
                case (r_cmd.kind)
                    K_ADD:       n_state = S_PRUNE_RD;
                    K_BAD_CLOCK: begin
                        n_res_status = ST_CLOCK;
                        n_state      = S_RESULT;
                    end
                    K_READ: begin
                        if (XW'(r_cmd.idx) < XW'(r_count)) begin
                            n_state = S_READ_WAIT;
                        end else begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RESULT;
                        end
                    end
                    K_CLEAR: begin
                        n_oldest = '0;
                        n_count  = '0;
                        n_state  = S_RESULT;
                    end
                    K_RESTORE: begin
                        if (r_count < CW'(CAPACITY)) begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_res_status = ST_FULL;
                        end
                        n_state = S_RESULT;
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_PRUNE_RD: begin
                // Read the oldest record; an empty store appends at once.
                rd_addr = r_oldest;
                n_state = (r_count == '0) ? S_APPEND : S_PRUNE_CHK;
            end
            S_PRUNE_CHK: begin
                if ((r_cmd.now >= rd_time) && (age > r_retention)) begin
                    n_oldest = slot(r_oldest, CW'(1));
                    n_count  = r_count - CW'(1);
                    n_state  = S_PRUNE_RD;
                end else begin
                    n_state = S_LAST_RD;
                end
            end
            S_LAST_RD: begin
                rd_addr = slot(r_oldest, r_count - CW'(1));
                n_state = S_LAST_CHK;
            end
            S_LAST_CHK: begin
                if (age < r_interval) begin
                    n_res_status = ST_SOON;
                    n_state      = S_RESULT;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                // When full the write lands on the oldest record, which moves on.
                mem_we = 1'b1;
                if (r_count < CW'(CAPACITY)) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_oldest = slot(r_oldest, CW'(1));
                end
                n_state = S_RESULT;
            end
            S_READ_WAIT: begin
                n_res_time  = rd_time;
                n_res_value = r_rd_data[VAL_W-1:0];
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_retention <= RETENTION_RESET;
            r_interval  <= INTERVAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            if (i_cfg_we && (i_cfg_index == CFG_RETENTION)) begin
                r_retention <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_INTERVAL)) begin
                r_interval <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: current command, result fields, output item.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        r_res_status <= n_res_status;
        r_res_time   <= n_res_time;
        r_res_value  <= n_res_value;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_count  <= r_count;
            r_out_time   <= r_res_time;
            r_out_value  <= r_res_value;
        end
    end

    // Record memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {r_cmd.now, r_cmd.value};
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out_status;
    assign o_result.stored_count = COUNT_W'(r_out_count);
    assign o_result.read_time    = r_out_time;
    assign o_result.read_value   = r_out_value;
endmodule

// File: hdl/timestamped_history_ring.sv
// ----------------------------------------------------------------------------
// timestamped_history_ring: ring store of timestamped records with retention
// Items on i_item request add, read, clear or restore; each gives one result
// item on o_result with a status, the record count and the read record.
//
// Usage:
//   Every accepted item yields exactly one result item, in order. The front
//   stage and a two-entry command queue keep taking items while the back
//   end works or while a result waits for the receiver; when the queue is
//   full, i_item.ready drops. A stalled receiver holds the result register
//   and the back end waits after finishing its current item.
//   An add walks the expired records one at a time, since the sequencer
//   reads one oldest record through the single memory read port and
//   checks it before the next. The back end takes a new item only once
//   the result of its current item is loaded into the result register.
//   Configuration writes take effect at once; the user makes them while
//   no item is in flight, and the block itself does not enforce this.
//   Reset empties the store and loads the default retention and interval;
//   record memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module timestamped_history_ring #(
    parameter int CAPACITY = thr_pkg::CAPACITY_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [thr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [thr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    thr_in_if.sink                          i_item,
    thr_out_if.source                       o_result
);
    import thr_pkg::*;

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic queue_valid;
    logic queue_ready;
    t_cmd queue_cmd;

    // Intake and classification.
    thr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    // Command queue between front and back end.
    thr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_cmd    (queue_cmd)
    );

    // Record store and sequencer.
    thr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_result    (o_result)
    );
endmodule

// File: sim/timestamped_history_ring_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timestamped_history_ring_tb: self-checking bench for the history ring
// Drives add, read, clear and restore items through the item channel with
// random sender gaps and receiver stalls. A scoreboard keeps its own copy of
// the ring and its limits and compares every result item field by field.
// ----------------------------------------------------------------------------
module timestamped_history_ring_tb;
    import thr_pkg::*;

    localparam int CAP          = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int SETTLE_TICKS = 12;

    typedef struct {
        t_status              status;
        logic [COUNT_W-1:0]   stored_count;
        logic [TIME_W-1:0]    read_time;
        logic [VAL_W-1:0]     read_value;
    } t_ring_result;

    // Scoreboard: mirrors the ring contents and queues the expected results.
    class t_ring_history_checker;
        logic [TIME_W-1:0]     rec_time [CAP];
        logic [VAL_W-1:0]      rec_value [CAP];
        int unsigned           oldest;
        int unsigned           held;
        logic [CFG_DATA_W-1:0] retention;
        logic [CFG_DATA_W-1:0] interval;
        t_ring_result          expected_results [$];
        int unsigned           mismatches;
        int unsigned           checked;

        function new();
            oldest     = 0;
            held       = 0;
            retention  = RETENTION_RESET;
            interval   = INTERVAL_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_limits(logic [CFG_DATA_W-1:0] ret, logic [CFG_DATA_W-1:0] intv);
            retention = ret;
            interval  = intv;
        endfunction

        function logic [TIME_W-1:0] newest_time();
            return (held > 0) ? rec_time[(oldest + held - 1) % CAP] : '0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void store_at_end(logic [TIME_W-1:0] now, logic [VAL_W-1:0] val);
            int unsigned slot;
            slot = (oldest + held) % CAP;
            rec_time[slot]  = now;
            rec_value[slot] = val;
        endfunction

        function t_status add_sample(logic [TIME_W-1:0] now, logic [VAL_W-1:0] val);
            logic [TIME_W-1:0] age;
            logic [TIME_W-1:0] since_newest;
            // A clock that is not yet set leaves the store untouched.
            if (now <= CLOCK_VALID_MIN)
                return ST_CLOCK;
            // Drop expired records from the oldest end; future records stay.
            while (held > 0) begin
                age = now - rec_time[oldest];
                if (now >= rec_time[oldest] && age > retention) begin
                    oldest = (oldest + 1) % CAP;
                    held--;
                end else begin
                    break;
                end
            end
            // Spacing check against the newest record, with a wrapping difference.
            if (held > 0) begin
                since_newest = now - newest_time();
                if (since_newest < interval)
                    return ST_SOON;
            end
            // Append; a full ring overwrites its oldest record.
            store_at_end(now, val);
            if (held < CAP)
                held++;
            else
                oldest = (oldest + 1) % CAP;
            return ST_DONE;
        endfunction

        function void note_item(t_opcode op, logic [TIME_W-1:0] now, logic [VAL_W-1:0] val,
                                logic [IDX_W-1:0] idx);
            t_ring_result res;
            res.status     = ST_DONE;
            res.read_time  = '0;
            res.read_value = '0;
            case (op)
                OP_ADD: begin
                    res.status = add_sample(now, val);
                end
                OP_READ: begin
                    if (idx < held) begin
                        res.read_time  = rec_time[(oldest + idx) % CAP];
                        res.read_value = rec_value[(oldest + idx) % CAP];
                    end else begin
                        res.status = ST_RANGE;
                    end
                end
                OP_CLEAR: begin
                    oldest = 0;
                    held   = 0;
                end
                default: begin
                    if (held < CAP) begin
                        store_at_end(now, val);
                        held++;
                    end else begin
                        res.status = ST_FULL;
                    end
                end
            endcase
            res.stored_count = COUNT_W'(held);
            expected_results = {expected_results, res};
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt,
                                   logic [TIME_W-1:0] rt, logic [VAL_W-1:0] rv);
            t_ring_result want;
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("error: result %0d arrived with nothing expected", checked);
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status || cnt !== want.stored_count ||
                rt !== want.read_time || rv !== want.read_value) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"error: result %0d expected status %0d count %0d time %h ",
                              "value %h, got status %0d count %0d time %h value %h"},
                             checked, want.status, want.stored_count, want.read_time,
                             want.read_value, st, cnt, rt, rv);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    thr_in_if  item_if ();
    thr_out_if result_if ();

    t_ring_history_checker  ring_check;
    bit                     idling_on;
    int unsigned            stall_left = 0;
    int unsigned            cycle_count = 0;
    logic [TIME_W-1:0]      wall_now;

    timestamped_history_ring DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: stalls in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (idling_on && stall_left > 0) begin
            result_if.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            result_if.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 9);
        end else begin
            result_if.ready <= 1'b1;
            stall_left      <= 0;
        end
    end

    // Result monitor and cycle counter.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && result_if.valid && result_if.ready)
            ring_check.check_result(result_if.status, result_if.stored_count,
                                    result_if.read_time, result_if.read_value);
    end

    // Watchdog for a hung handshake.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Offers one item, optionally after a sender gap, and waits for acceptance.
    task automatic send_item(input t_opcode op, input logic [TIME_W-1:0] now,
                             input logic [VAL_W-1:0] val, input logic [IDX_W-1:0] idx);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.opcode       <= op;
        item_if.now_seconds  <= now;
        item_if.sample_value <= val;
        item_if.entry_index  <= idx;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        ring_check.note_item(op, now, val, idx);
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic drain_results(input int unsigned settle);
        item_if.valid <= 1'b0;
        while (ring_check.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes both limits while the ring is idle.
    task automatic program_limits(input logic [CFG_DATA_W-1:0] ret,
                                  input logic [CFG_DATA_W-1:0] intv);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RETENTION;
        cfg_data  <= ret;
        @(posedge i_clk);
        cfg_index <= CFG_INTERVAL;
        cfg_data  <= intv;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        ring_check.set_limits(ret, intv);
    endtask

    // One random item, mostly plausible sample times around wall_now, the bench's running clock.
    task automatic send_random_item();
        int unsigned        pick;
        int unsigned        kind;
        logic [TIME_W-1:0]  newest;
        logic [TIME_W-1:0]  now;
        logic [VAL_W-1:0]   val;
        logic [IDX_W-1:0]   idx;
        t_opcode            op;
        newest = (ring_check.held > 0) ? ring_check.newest_time() : wall_now;
        now    = $urandom;
        val    = $urandom;
        idx    = IDX_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 15))
            0:       val = '0;
            1:       val = '1;
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            op   = OP_ADD;
            kind = $urandom_range(0, 15);
            case (kind)
                0:        now = $urandom_range(0, CLOCK_VALID_MIN);
                1:        now = newest + ring_check.interval - 1;
                2:        now = newest + ring_check.interval;
                3, 4, 5, 6, 7, 8, 9, 10:
                          now = wall_now + ring_check.interval + $urandom_range(0, 50000);
                11, 12:   now = wall_now + ring_check.retention + $urandom_range(1, 200000);
                13:       now = wall_now - $urandom_range(1, 100000);
                default:  ;
            endcase
            if (kind >= 3 && kind <= 12 && now > CLOCK_VALID_MIN)
                wall_now = now;
        end else if (pick < 86) begin
            op = OP_READ;
            if (ring_check.held > 0 && $urandom_range(0, 7) != 0)
                idx = IDX_W'($urandom_range(0, ring_check.held - 1));
        end else if (pick < 98) begin
            op = OP_RESTORE;
            if ($urandom_range(0, 1) == 0)
                now = wall_now + $urandom_range(0, 50000);
        end else begin
            op = OP_CLEAR;
        end
        send_item(op, now, val, idx);
    endtask

    initial begin
        ring_check           = new();
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_RETENTION;
        cfg_data             = '0;
        item_if.valid        = 1'b0;
        item_if.opcode       = OP_ADD;
        item_if.now_seconds  = '0;
        item_if.sample_value = '0;
        item_if.entry_index  = '0;
        idling_on            = 1'b1;
        wall_now             = CLOCK_VALID_MIN + 500_000_000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset limits.
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_ADD, 0, 0, '1);
        send_item(OP_ADD, CLOCK_VALID_MIN, '1, 0);
        send_item(OP_ADD, CLOCK_VALID_MIN + 1, 32'hFFFF_FFFF, 0);
        send_item(OP_ADD, CLOCK_VALID_MIN + INTERVAL_RESET, 32'h1, 0);
        send_item(OP_ADD, CLOCK_VALID_MIN + 1 + INTERVAL_RESET, 32'h0, 0);
        send_item(OP_READ, '1, '1, 0);
        send_item(OP_READ, 0, 0, 1);
        send_item(OP_READ, 0, 0, 2);
        send_item(OP_READ, 0, 0, '1);
        // A record in the future must survive the prune of the two older ones.
        send_item(OP_RESTORE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 0);
        send_item(OP_ADD, CLOCK_VALID_MIN + 3_000_000, 32'h5A5A_5A5A, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 0, 0, 1);
        send_item(OP_CLEAR, '1, '1, '1);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_RESTORE, 0, 32'h1234_5678, 0);
        send_item(OP_RESTORE, 32'h7FFF_FFFF, 32'hFEDC_BA98, 0);
        send_item(OP_READ, 0, 0, 1);
        send_item(OP_ADD, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        drain_results(SETTLE_TICKS);

        // Nothing expires and no spacing: fill the ring, refuse restores, overwrite.
        program_limits(32'hFFFF_FFFF, 32'h0);
        repeat (CAP + 6) send_item(OP_RESTORE, $urandom, $urandom,
                                   IDX_W'($urandom_range(0, 1023)));
        send_item(OP_READ, 0, 0, '1);
        repeat (20) send_item(OP_ADD, wall_now + $urandom_range(0, 50000), $urandom, 0);
        send_item(OP_READ, 0, 0, '1);
        repeat (40) send_random_item();
        drain_results(SETTLE_TICKS);

        // Everything past expires at once; only an exact full-range gap is spaced enough.
        program_limits(32'h0, 32'hFFFF_FFFF);
        repeat (60) send_random_item();
        drain_results(SETTLE_TICKS);

        // Short retention with a steady stream, paused once until all results are back.
        program_limits(32'd100000, 32'd1000);
        repeat (80) send_random_item();
        drain_results(0);
        repeat (80) send_random_item();
        drain_results(SETTLE_TICKS);

        // Back to the reset limits with both sides running flat out.
        program_limits(RETENTION_RESET, INTERVAL_RESET);
        idling_on = 1'b0;
        repeat (110) send_random_item();
        drain_results(20);

        if (ring_check.mismatches == 0 && ring_check.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hdl/thr_pkg.sv
hdl/thr_in_if.sv
hdl/thr_out_if.sv
hdl/thr_front.sv
hdl/thr_queue.sv
hdl/thr_back.sv
hdl/timestamped_history_ring.sv
sim/timestamped_history_ring_tb.sv
